FILE: rtl/core/mbe_pkg.sv
// shared types, constants and state encodings for the mandelbrot escape test
package mbe_pkg;

  localparam int FRAC_BITS  = 28;
  localparam int COUNT_BITS = 12;
  localparam int POINT_W    = 32;
  localparam int BUDGET_W   = 12;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // orbit values and their squares, Q8.FRAC
  localparam int ORBIT_W = FRAC_BITS + 8;
  // multiplier operand: room for 2*z_re and the wide shortcut terms
  localparam int MUL_W   = ORBIT_W + 2;
  localparam int HALF_W  = (MUL_W + 1) / 2;
  localparam int MAG_W   = 2 * HALF_W;
  // truncated signed product
  localparam int PROD_W  = 2 * MAG_W - FRAC_BITS + 1;
  localparam int SUM_W   = PROD_W + 1;
  localparam int ESC_W   = ORBIT_W + 1;

  typedef logic signed [POINT_W-1:0] point_t;
  typedef logic signed [ORBIT_W-1:0] orbit_t;
  typedef logic signed [MUL_W-1:0]   mul_op_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic [COUNT_BITS-1:0]     count_t;
  typedef logic [BUDGET_W-1:0]       budget_t;

  localparam budget_t BUDGET_RESET = BUDGET_W'(40);
  localparam count_t  COUNT_MAX    = '1;

  localparam orbit_t ORBIT_MAX = {1'b0, {(ORBIT_W-1){1'b1}}};
  localparam orbit_t ORBIT_MIN = {1'b1, {(ORBIT_W-1){1'b0}}};

  localparam mul_op_t FX_ONE     = MUL_W'(1) << FRAC_BITS;
  localparam mul_op_t FX_QUARTER = MUL_W'(1) << (FRAC_BITS - 2);
  localparam prod_t   FX_SIXTEENTH = PROD_W'(1) << (FRAC_BITS - 4);
  localparam logic signed [ESC_W-1:0] FX_FOUR = ESC_W'(4) << FRAC_BITS;

  // one queued point with its shortcut verdict
  typedef struct packed {
    point_t re;
    point_t im;
    logic   hit;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_SQ,
    FR_SQ_W,
    FR_SUM,
    FR_LHS,
    FR_LHS_W,
    FR_DECIDE,
    FR_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_STEP,
    BK_W1,
    BK_IM,
    BK_SQIM,
    BK_W4,
    BK_SQ_DONE,
    BK_DONE
  } back_state_t;

endpackage

FILE: rtl/core/mbe_if.sv
// request channels: complex point in, membership verdict out
interface mbe_point_if;
  logic            valid;
  logic            ready;
  mbe_pkg::point_t point_re;
  mbe_pkg::point_t point_im;

  modport source (output valid, output point_re, output point_im, input ready);
  modport sink (input valid, input point_re, input point_im, output ready);
endinterface

interface mbe_result_if;
  logic valid;
  logic ready;
  logic inside_set;

  modport source (output valid, output inside_set, input ready);
  modport sink (input valid, input inside_set, output ready);
endinterface

FILE: rtl/core/mbe_mul.sv
// two-stage signed fixed-point multiplier, product truncated toward zero
module mbe_mul (
  input  logic             clk,
  input  mbe_pkg::mul_op_t a,
  input  mbe_pkg::mul_op_t b,
  output mbe_pkg::prod_t   p
);

  localparam int HW = mbe_pkg::HALF_W;
  localparam int MW = mbe_pkg::MAG_W;

  logic signed [MW-1:0] a_ext, b_ext;
  logic [MW-1:0]        mag_a, mag_b;
  logic [2*HW-1:0]      pp_ll_r, pp_lh_r, pp_hl_r, pp_hh_r;
  logic                 neg_r;
  logic [2*HW:0]        mid;
  logic [2*MW-1:0]      full;
  mbe_pkg::prod_t       mag_p;
  mbe_pkg::prod_t       p_r;

  assign a_ext = MW'(a);
  assign b_ext = MW'(b);
  assign mag_a = a[mbe_pkg::MUL_W-1] ? unsigned'(-a_ext) : unsigned'(a_ext);
  assign mag_b = b[mbe_pkg::MUL_W-1] ? unsigned'(-b_ext) : unsigned'(b_ext);

  // stage 1: four partial products of the magnitudes
  always_ff @(posedge clk) begin
    pp_ll_r <= mag_a[HW-1:0]  * mag_b[HW-1:0];
    pp_lh_r <= mag_a[HW-1:0]  * mag_b[MW-1:HW];
    pp_hl_r <= mag_a[MW-1:HW] * mag_b[HW-1:0];
    pp_hh_r <= mag_a[MW-1:HW] * mag_b[MW-1:HW];
    neg_r   <= a[mbe_pkg::MUL_W-1] ^ b[mbe_pkg::MUL_W-1];
  end

  // stage 2: combine, drop fraction bits, restore sign
  assign mid   = (2*HW+1)'(pp_lh_r) + (2*HW+1)'(pp_hl_r);
  assign full  = {pp_hh_r, pp_ll_r} + ((2*MW)'(mid) << HW);
  assign mag_p = mbe_pkg::prod_t'({1'b0, full[2*MW-1:mbe_pkg::FRAC_BITS]});

  always_ff @(posedge clk) begin
    p_r <= neg_r ? -mag_p : mag_p;
  end

  assign p = p_r;

endmodule

FILE: rtl/core/mbe_fifo.sv
// short request queue between shortcut front end and orbit back end
module mbe_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mbe_pkg::item_t      push_item,
  input  logic                pop,
  output mbe_pkg::item_t      pop_item,
  output mbe_pkg::fifo_stat_t stat
);

  localparam int PW = mbe_pkg::FIFO_PTR_W;
  localparam int DEPTH = mbe_pkg::FIFO_DEPTH;

  mbe_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]    cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign pop_item   = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == (PW+1)'(DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

FILE: rtl/core/mbe_front.sv
// front end: accepts points and runs the cardioid and bulb tests
module mbe_front (
  input  logic                clk,
  input  logic                rst_n,
  mbe_point_if.sink           in_chan,
  output logic                push,
  output mbe_pkg::item_t      push_item,
  input  mbe_pkg::fifo_stat_t stat
);

  mbe_pkg::front_state_t state_r, state_nxt;

  mbe_pkg::point_t  re_r, im_r;
  mbe_pkg::mul_op_t dre_r, bulb_r, q_r, qd_r;
  mbe_pkg::prod_t   im2_r;
  logic             bulb_hit_r, hit_r;

  mbe_pkg::mul_op_t im_op, op0_a, op0_b, q_sum;
  mbe_pkg::prod_t   p0, p1, p2, bulb_sum;
  logic             accept;

  assign accept = in_chan.valid && in_chan.ready;
  assign im_op  = mbe_pkg::MUL_W'(im_r);

  // unit 0 squares im first, then forms q * (q + dre)
  assign op0_a = (state_r == mbe_pkg::FR_LHS) ? q_r  : im_op;
  assign op0_b = (state_r == mbe_pkg::FR_LHS) ? qd_r : im_op;

  mbe_mul u_mul0 (.clk(clk), .a(op0_a), .b(op0_b), .p(p0));
  mbe_mul u_mul1 (.clk(clk), .a(dre_r), .b(dre_r), .p(p1));
  mbe_mul u_mul2 (.clk(clk), .a(bulb_r), .b(bulb_r), .p(p2));

  assign q_sum    = mbe_pkg::MUL_W'(p1) + mbe_pkg::MUL_W'(p0);
  assign bulb_sum = p2 + p0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mbe_pkg::FR_IDLE:   if (in_chan.valid) state_nxt = mbe_pkg::FR_SQ;
      mbe_pkg::FR_SQ:     state_nxt = mbe_pkg::FR_SQ_W;
      mbe_pkg::FR_SQ_W:   state_nxt = mbe_pkg::FR_SUM;
      mbe_pkg::FR_SUM:    state_nxt = mbe_pkg::FR_LHS;
      mbe_pkg::FR_LHS:    state_nxt = mbe_pkg::FR_LHS_W;
      mbe_pkg::FR_LHS_W:  state_nxt = mbe_pkg::FR_DECIDE;
      mbe_pkg::FR_DECIDE: state_nxt = mbe_pkg::FR_PUSH;
      mbe_pkg::FR_PUSH:   if (!stat.full) state_nxt = mbe_pkg::FR_IDLE;
      default:            state_nxt = mbe_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    in_chan.ready = 1'b0;
    push          = 1'b0;
    case (state_r)
      mbe_pkg::FR_IDLE: in_chan.ready = 1'b1;
      mbe_pkg::FR_PUSH: push = !stat.full;
      default: begin
        in_chan.ready = 1'b0;
        push          = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mbe_pkg::FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      re_r   <= in_chan.point_re;
      im_r   <= in_chan.point_im;
      dre_r  <= mbe_pkg::MUL_W'(in_chan.point_re) - mbe_pkg::FX_QUARTER;
      bulb_r <= mbe_pkg::MUL_W'(in_chan.point_re) + mbe_pkg::FX_ONE;
    end
    if (state_r == mbe_pkg::FR_SUM) begin
      im2_r      <= p0;
      q_r        <= q_sum;
      qd_r       <= q_sum + dre_r;
      bulb_hit_r <= (bulb_sum <= mbe_pkg::FX_SIXTEENTH);
    end
    if (state_r == mbe_pkg::FR_DECIDE) begin
      hit_r <= bulb_hit_r || (p0 <= (im2_r >>> 2));
    end
  end

  assign push_item.re  = re_r;
  assign push_item.im  = im_r;
  assign push_item.hit = hit_r;

endmodule

FILE: rtl/core/mbe_back.sv
// back end: iterates z = z*z + c and holds the verdict for the receiver
module mbe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mbe_pkg::budget_t    budget,
  input  mbe_pkg::item_t      pop_item,
  output logic                pop,
  input  mbe_pkg::fifo_stat_t stat,
  mbe_result_if.source        out_chan
);

  localparam int SW = mbe_pkg::SUM_W;
  localparam int EW = mbe_pkg::ESC_W;

  function automatic mbe_pkg::orbit_t clamp_orbit(input logic signed [SW-1:0] v);
    mbe_pkg::orbit_t r;
    if (v > SW'(mbe_pkg::ORBIT_MAX)) begin
      r = mbe_pkg::ORBIT_MAX;
    end else if (v < SW'(mbe_pkg::ORBIT_MIN)) begin
      r = mbe_pkg::ORBIT_MIN;
    end else begin
      r = mbe_pkg::orbit_t'(v);
    end
    return r;
  endfunction

  function automatic mbe_pkg::orbit_t sat_square(input mbe_pkg::prod_t v);
    mbe_pkg::orbit_t r;
    if (v > mbe_pkg::PROD_W'(mbe_pkg::ORBIT_MAX)) begin
      r = mbe_pkg::ORBIT_MAX;
    end else begin
      r = mbe_pkg::orbit_t'(v);
    end
    return r;
  endfunction

  mbe_pkg::back_state_t state_r, state_nxt;

  mbe_pkg::point_t c_re_r, c_im_r;
  mbe_pkg::orbit_t z_re_r, z_im_r, sq_re_r, sq_im_r;
  mbe_pkg::count_t count_r, lim_r, lim;
  logic            res_r;
  logic            out_valid_r, out_inside_r;

  mbe_pkg::mul_op_t         op_a, op_b, z_re_op, z_im_op;
  mbe_pkg::prod_t           p_a, p_b;
  logic signed [SW-1:0]     re_sum, im_sum;
  logic signed [EW-1:0]     mag2;
  logic                     finish, slot_free;
  logic                     take, step_go, load_out;

  assign z_re_op = mbe_pkg::MUL_W'(z_re_r);
  assign z_im_op = mbe_pkg::MUL_W'(z_im_r);

  // unit a: 2*z_re*z_im, then z_im squared; unit b: z_re squared
  assign op_a = (state_r == mbe_pkg::BK_SQIM) ? z_im_op
              : mbe_pkg::mul_op_t'(signed'({z_re_r, 1'b0}));
  assign op_b = z_im_op;

  mbe_mul u_mul_a (.clk(clk), .a(op_a), .b((state_r == mbe_pkg::BK_SQIM) ? z_im_op : op_b),
                   .p(p_a));
  mbe_mul u_mul_b (.clk(clk), .a(z_re_op), .b(z_re_op), .p(p_b));

  assign re_sum = SW'(sq_re_r) - SW'(sq_im_r) + SW'(c_re_r);
  assign im_sum = SW'(p_a) + SW'(c_im_r);
  assign mag2   = EW'(sq_re_r) + EW'(sq_im_r);
  assign finish = (mag2 > mbe_pkg::FX_FOUR) || (count_r >= lim_r);
  assign lim    = (32'(budget) > 32'(mbe_pkg::COUNT_MAX)) ? mbe_pkg::COUNT_MAX
                : mbe_pkg::count_t'(budget);
  assign slot_free = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mbe_pkg::BK_IDLE: begin
        if (!stat.empty) begin
          state_nxt = pop_item.hit ? mbe_pkg::BK_DONE : mbe_pkg::BK_STEP;
        end
      end
      mbe_pkg::BK_STEP:    state_nxt = finish ? mbe_pkg::BK_DONE : mbe_pkg::BK_W1;
      mbe_pkg::BK_W1:      state_nxt = mbe_pkg::BK_IM;
      mbe_pkg::BK_IM:      state_nxt = mbe_pkg::BK_SQIM;
      mbe_pkg::BK_SQIM:    state_nxt = mbe_pkg::BK_W4;
      mbe_pkg::BK_W4:      state_nxt = mbe_pkg::BK_SQ_DONE;
      mbe_pkg::BK_SQ_DONE: state_nxt = mbe_pkg::BK_STEP;
      mbe_pkg::BK_DONE:    if (slot_free) state_nxt = mbe_pkg::BK_IDLE;
      default:             state_nxt = mbe_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    take     = 1'b0;
    step_go  = 1'b0;
    load_out = 1'b0;
    case (state_r)
      mbe_pkg::BK_IDLE: take     = !stat.empty;
      mbe_pkg::BK_STEP: step_go  = !finish;
      mbe_pkg::BK_DONE: load_out = slot_free;
      default: begin
        take     = 1'b0;
        step_go  = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  assign pop = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbe_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_inside_r <= res_r;
    end
    if (take) begin
      c_re_r  <= pop_item.re;
      c_im_r  <= pop_item.im;
      z_re_r  <= '0;
      z_im_r  <= '0;
      sq_re_r <= '0;
      sq_im_r <= '0;
      count_r <= '0;
      lim_r   <= lim;
      res_r   <= 1'b1;
    end
    if ((state_r == mbe_pkg::BK_STEP) && finish) begin
      res_r <= (count_r == lim_r);
    end
    if (step_go) begin
      z_re_r <= clamp_orbit(re_sum);
    end
    if (state_r == mbe_pkg::BK_IM) begin
      z_im_r <= clamp_orbit(im_sum);
    end
    if (state_r == mbe_pkg::BK_SQIM) begin
      sq_re_r <= sat_square(p_b);
    end
    if (state_r == mbe_pkg::BK_SQ_DONE) begin
      sq_im_r <= sat_square(p_a);
      count_r <= mbe_pkg::count_t'(count_r + 1'b1);
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.inside_set = out_inside_r;

endmodule

FILE: rtl/core/mandelbrot_escape_test.sv
// top level of the mandelbrot membership test
//
// in_chan carries one complex point c (point_re, point_im, signed Q4.28);
// out_chan returns one inside_set bit per point, in request order.
// cfg_wr_en / cfg_wr_data write the iteration budget (reset value 40);
// write it only while no request is in flight.
// front end: after a request is taken, the cardioid and period-2 bulb tests
// run on three two-stage multipliers (square, sum, cardioid product, decide)
// and the verdict lands in a two-entry queue; no new request is taken until
// that verdict is pushed, which waits while the queue is full. back end: a
// point that matched a shortcut goes straight to the done state after it
// leaves the queue. otherwise each orbit step runs the multiply, add, square
// chain through two pipelined multipliers, for up to budget steps.
// the result sits in an output register, so the back end starts the next
// point while the receiver stalls; the queue then fills and in_chan.ready
// drops. synchronous active-low reset empties the queue and the output.
module mandelbrot_escape_test (
  input  logic                   clk,
  input  logic                   rst_n,
  mbe_point_if.sink              in_chan,
  mbe_result_if.source           out_chan,
  input  logic                   cfg_wr_en,
  input  logic [mbe_pkg::BUDGET_W-1:0] cfg_wr_data
);

  mbe_pkg::budget_t    budget_r;
  mbe_pkg::item_t      push_item, pop_item;
  mbe_pkg::fifo_stat_t fifo_stat;
  logic                push, pop;

  // iteration budget register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= mbe_pkg::BUDGET_RESET;
    end else if (cfg_wr_en) begin
      budget_r <= cfg_wr_data;
    end
  end

  // shortcut tests
  mbe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .push      (push),
    .push_item (push_item),
    .stat      (fifo_stat)
  );

  // decouples the two halves
  mbe_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (fifo_stat)
  );

  // orbit iteration and output register
  mbe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .budget   (budget_r),
    .pop_item (pop_item),
    .pop      (pop),
    .stat     (fifo_stat),
    .out_chan (out_chan)
  );

`ifndef SYNTH
  // front end only pushes when the queue has room
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fifo_stat.full)
    else $error("queue push while full");

  // back end only pops a queued request
  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !fifo_stat.empty)
    else $error("queue pop while empty");

  // reset drops any pending result
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("result valid after reset");
`endif

endmodule
